// ===== rtl/core/pfl_pkg.sv =====
// Package for the page free-list allocator: sizes, mode and status codes,
// and the write-request types of the link and count memories.
// No dependencies.
package pfl_pkg;

    localparam int NUM_PAGES  = 8192;
    localparam int PAGE_BYTES = 4096;
    localparam int COUNT_BITS = 16;

    // Fixed field widths of the ports
    localparam int ADDR_W   = 25;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int REF_W    = 16;
    localparam int TOTAL_W  = 14;

    localparam int PAGE_IDX_W = $clog2(NUM_PAGES);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int IDX_HI_W   = ADDR_W - PAGE_SHIFT;
    localparam int FREE_W     = $clog2(NUM_PAGES + 1);

    typedef logic [PAGE_IDX_W-1:0] page_idx_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [FREE_W-1:0]     free_cnt_t;

    localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INC   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEC   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUERY = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd2;

    typedef struct packed {
        logic      en;
        page_idx_t addr;
        page_idx_t data;
    } link_wr_t;

    typedef struct packed {
        logic      en;
        page_idx_t addr;
        count_t    data;
    } ref_wr_t;

endpackage

// ===== rtl/core/page_free_list_refcount.sv =====
// Page allocator top level: LIFO free list with per-page reference counts.
// Depends on pfl_pkg, pfl_link_ram and pfl_ref_ram.
//
//  channel   handshake              beat contents
//  -------   ---------------------  ----------------------------------------
//  in        in_valid / in_stall    mode, page_address
//  out       out_valid / out_stall  result_address, status, ref_count,
//                                   free_total
//  cfg       cfg_valid / cfg_ready  cfg_data (first_page_address)
//
// Each operation is accepted in ST_IDLE, where the link and count memories
// are read, and completed in ST_WORK, which modifies, writes back and loads
// the output register; in_stall stays high until that write-back is done.
// A result waiting on out_stall holds the block in ST_WORK only if the
// output register is still full; otherwise it writes back and returns to
// ST_IDLE for the next beat. After reset a clearing pass zeroes the count
// memory with in_stall high; configuration writes are taken throughout.
module page_free_list_refcount
    import pfl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic [MODE_W-1:0]   mode,
    input  logic [ADDR_W-1:0]   page_address,

    output logic                out_valid,
    input  logic                out_stall,
    output logic [ADDR_W-1:0]   result_address,
    output logic [STATUS_W-1:0] status,
    output logic [REF_W-1:0]    ref_count,
    output logic [TOTAL_W-1:0]  free_total,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ADDR_W-1:0]   cfg_data
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_WORK  = 3'b100
    } state_t;

    localparam logic [IDX_HI_W:0] NUM_PAGES_HI = (IDX_HI_W + 1)'(NUM_PAGES);
    localparam page_idx_t         LAST_PAGE    = PAGE_IDX_W'(NUM_PAGES - 1);
    localparam free_cnt_t         FREE_MAX     = FREE_W'(NUM_PAGES);

    state_t              state_reg, state_next;
    page_idx_t           clr_idx_reg;
    logic [ADDR_W-1:0]   first_page_reg;
    page_idx_t           head_reg, head_next;
    free_cnt_t           free_reg, free_next;

    logic [MODE_W-1:0]   mode_reg;
    page_idx_t           page_reg;
    logic                free_bad_reg;
    logic                range_bad_reg;

    logic                out_valid_reg;
    logic [ADDR_W-1:0]   result_address_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [REF_W-1:0]    ref_count_reg;
    logic [TOTAL_W-1:0]  free_total_reg;

    logic                accept;
    logic                commit;
    logic [IDX_HI_W-1:0] addr_hi;
    logic                in_range;
    page_idx_t           in_page;
    page_idx_t           rd_page;

    link_wr_t            link_wr;
    ref_wr_t             ref_wr;
    page_idx_t           link_rd_data;
    count_t              ref_rd_data;
    count_t              ref_new;

    logic [ADDR_W-1:0]   res_addr;
    logic [STATUS_W-1:0] res_status;
    logic [REF_W-1:0]    res_ref;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign commit    = (state_reg == ST_WORK) && (!out_valid_reg || !out_stall);

    assign addr_hi  = page_address[ADDR_W-1:PAGE_SHIFT];
    assign in_range = ({1'b0, addr_hi} < NUM_PAGES_HI);
    assign in_page  = addr_hi[PAGE_IDX_W-1:0];
    assign rd_page  = (mode == MODE_ALLOC) ? head_reg : in_page;

    pfl_link_ram u_link_ram (
        .clk     (clk),
        .wr      (link_wr),
        .rd_en   (accept),
        .rd_addr (head_reg),
        .rd_data (link_rd_data)
    );

    pfl_ref_ram u_ref_ram (
        .clk     (clk),
        .wr      (ref_wr),
        .rd_en   (accept),
        .rd_addr (rd_page),
        .rd_data (ref_rd_data)
    );

    // Modify stage: decide the write-back and the result from the read data
    always_comb
    begin
        head_next      = head_reg;
        free_next      = free_reg;
        link_wr        = '0;
        ref_wr         = '0;
        ref_new        = ref_rd_data;
        res_addr       = '0;
        res_status     = STATUS_OK;
        res_ref        = '0;

        case (mode_reg)
            MODE_ALLOC:
            begin
                if (free_reg == '0)
                begin
                    res_status = STATUS_EMPTY;
                end
                else
                begin
                    ref_new   = ref_rd_data + 1'b1;
                    head_next = link_rd_data;
                    free_next = free_reg - 1'b1;
                    ref_wr    = '{en: commit, addr: page_reg, data: ref_new};
                    res_addr  = ADDR_W'({page_reg, {PAGE_SHIFT{1'b0}}});
                    res_ref   = REF_W'(ref_new);
                end
            end
            MODE_FREE:
            begin
                if (free_bad_reg)
                begin
                    res_status = STATUS_BAD;
                end
                else
                begin
                    ref_new   = ref_rd_data - 1'b1;
                    head_next = page_reg;
                    if (free_reg < FREE_MAX)
                    begin
                        free_next = free_reg + 1'b1;
                    end
                    link_wr = '{en: commit, addr: page_reg, data: head_reg};
                    ref_wr  = '{en: commit, addr: page_reg, data: ref_new};
                    res_ref = REF_W'(ref_new);
                end
            end
            MODE_INC, MODE_DEC:
            begin
                if (range_bad_reg)
                begin
                    res_status = STATUS_BAD;
                end
                else
                begin
                    ref_new = (mode_reg == MODE_INC) ? ref_rd_data + 1'b1
                                                     : ref_rd_data - 1'b1;
                    ref_wr  = '{en: commit, addr: page_reg, data: ref_new};
                    res_ref = REF_W'(ref_new);
                end
            end
            default:
            begin
                // query and undefined modes report the total only
                res_status = STATUS_OK;
            end
        endcase

        // clearing pass owns the count write port after reset
        if (state_reg == ST_CLEAR)
        begin
            ref_wr = '{en: 1'b1, addr: clr_idx_reg, data: '0};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == LAST_PAGE)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_WORK;
                end
            end
            ST_WORK:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            first_page_reg <= '0;
            head_reg       <= '0;
            free_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                first_page_reg <= cfg_data;
            end
            if (commit)
            begin
                head_reg      <= head_next;
                free_reg      <= free_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: the accepted beat and the output beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg      <= mode;
            page_reg      <= rd_page;
            range_bad_reg <= !in_range;
            free_bad_reg  <= !in_range
                             || (page_address[PAGE_SHIFT-1:0] != '0)
                             || (page_address < first_page_reg);
        end
        if (commit)
        begin
            result_address_reg <= res_addr;
            status_reg         <= res_status;
            ref_count_reg      <= res_ref;
            free_total_reg     <= TOTAL_W'(free_next);
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_address = result_address_reg;
    assign status         = status_reg;
    assign ref_count      = ref_count_reg;
    assign free_total     = free_total_reg;

endmodule

// ===== rtl/core/pfl_link_ram.sv =====
// Link memory of the free list: one next-page index per page.
// Synchronous, one write and one read port, read data registered.
// Depends on pfl_pkg.
module pfl_link_ram
    import pfl_pkg::*;
(
    input  logic      clk,
    input  link_wr_t  wr,
    input  logic      rd_en,
    input  page_idx_t rd_addr,
    output page_idx_t rd_data
);

    page_idx_t mem [NUM_PAGES];
    page_idx_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        // hold the last read word while no read is issued
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/pfl_ref_ram.sv =====
// Reference-count memory: one count per page.
// Synchronous, one write and one read port, read data registered.
// Depends on pfl_pkg.
module pfl_ref_ram
    import pfl_pkg::*;
(
    input  logic      clk,
    input  ref_wr_t   wr,
    input  logic      rd_en,
    input  page_idx_t rd_addr,
    output count_t    rd_data
);

    count_t mem [NUM_PAGES];
    count_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        // hold the last read word while no read is issued
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for page_free_list_refcount: drives allocate, free,
// count and query beats, predicts every result in a scoreboard class and
// compares it field by field. Depends on pfl_pkg and the RTL top level only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfl_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int POOL_PAGES     = 24;
    localparam int MAX_SHOWN      = 40;
    localparam int FILL_FREES     = 40;
    localparam int DRAIN_ALLOCS   = 120;

    // Modes with no meaning of their own; the block treats them as a query
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [STATUS_W-1:0] status;
        logic [REF_W-1:0]    refs;
        logic [TOTAL_W-1:0]  total;
    } alloc_result_t;

    class alloc_scoreboard;
        page_idx_t         link_mem [NUM_PAGES];
        count_t            ref_mem  [NUM_PAGES];
        page_idx_t         head;
        free_cnt_t         held;
        logic [ADDR_W-1:0] first_page;
        alloc_result_t     expected_q [$];
        int                errors;
        int                shown;

        function new();
            foreach (ref_mem[i])
            begin
                ref_mem[i]  = '0;
                link_mem[i] = '0;
            end
            head       = '0;
            held       = '0;
            first_page = '0;
            errors     = 0;
            shown      = 0;
        endfunction

        task flag(input string msg);
            errors++;
            if (shown < MAX_SHOWN)
            begin
                shown++;
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endtask

        function void set_first_page(input logic [ADDR_W-1:0] v);
            first_page = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the allocator state by one accepted beat and queue its result
        function void note_input(input logic [MODE_W-1:0] m, input logic [ADDR_W-1:0] a);
            alloc_result_t r;
            page_idx_t     pg;
            r        = '0;
            r.status = STATUS_OK;
            pg       = page_idx_t'(a >> PAGE_SHIFT);
            case (m)
                MODE_ALLOC:
                begin
                    if (held == 0)
                        r.status = STATUS_EMPTY;
                    else
                    begin
                        pg          = head;
                        head        = link_mem[pg];
                        held        = held - 1'b1;
                        ref_mem[pg] = ref_mem[pg] + 1'b1;
                        r.addr      = ADDR_W'(pg) << PAGE_SHIFT;
                        r.refs      = ref_mem[pg];
                    end
                end
                MODE_FREE:
                begin
                    if (a[PAGE_SHIFT-1:0] != '0 || a < first_page
                        || int'(a) >= NUM_PAGES * PAGE_BYTES)
                        r.status = STATUS_BAD;
                    else
                    begin
                        link_mem[pg] = head;
                        head         = pg;
                        if (held < NUM_PAGES)
                            held = held + 1'b1;
                        ref_mem[pg] = ref_mem[pg] - 1'b1;
                        r.refs      = ref_mem[pg];
                    end
                end
                MODE_INC, MODE_DEC:
                begin
                    if (int'(a >> PAGE_SHIFT) >= NUM_PAGES)
                        r.status = STATUS_BAD;
                    else
                    begin
                        if (m == MODE_INC)
                            ref_mem[pg] = ref_mem[pg] + 1'b1;
                        else
                            ref_mem[pg] = ref_mem[pg] - 1'b1;
                        r.refs = ref_mem[pg];
                    end
                end
                default:
                begin
                end
            endcase
            r.total = TOTAL_W'(held);
            expected_q.push_back(r);
        endfunction

        task check_result(input logic [ADDR_W-1:0] addr, input logic [STATUS_W-1:0] st,
                          input logic [REF_W-1:0] refs, input logic [TOTAL_W-1:0] total);
            alloc_result_t e;
            if (expected_q.size() == 0)
                flag($sformatf("result beat with no operation pending (addr %h)", addr));
            else
            begin
                e = expected_q.pop_front();
                if (addr !== e.addr)
                    flag($sformatf("result_address %h, expected %h", addr, e.addr));
                if (st !== e.status)
                    flag($sformatf("status %0d, expected %0d", st, e.status));
                if (refs !== e.refs)
                    flag($sformatf("ref_count %h, expected %h", refs, e.refs));
                if (total !== e.total)
                    flag($sformatf("free_total %0d, expected %0d", total, e.total));
            end
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [MODE_W-1:0]   mode;
    logic [ADDR_W-1:0]   page_address;
    logic                out_valid;
    logic                out_stall;
    logic [ADDR_W-1:0]   result_address;
    logic [STATUS_W-1:0] status;
    logic [REF_W-1:0]    ref_count;
    logic [TOTAL_W-1:0]  free_total;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [ADDR_W-1:0]   cfg_data;

    alloc_scoreboard sb;
    int              burst_left;
    int              pool_base;
    int              stall_left;
    int              stall_style;
    int              idle_cycles;

    page_free_list_refcount uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .page_address   (page_address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_address (result_address),
        .status         (status),
        .ref_count      (ref_count),
        .free_total     (free_total),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    // Receiver: pick a new random stall style each time the current one runs out
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(8, 80);
        end
        stall_left--;
        case (stall_style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= ((stall_left % 16) < 11);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(result_address, status, ref_count, free_total);
            if (in_valid && !in_stall)
                sb.note_input(mode, page_address);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("** page_free_list_refcount: FAILED **");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] pool_address();
        return ADDR_W'(pool_base + $urandom_range(0, POOL_PAGES - 1)) << PAGE_SHIFT;
    endfunction

    // Send one beat; open a new burst after a random gap when the old one ends
    task automatic send_op(input logic [MODE_W-1:0] m, input logic [ADDR_W-1:0] a);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        mode         <= m;
        page_address <= a;
        do @(posedge clk); while (in_stall);
    endtask

    // Hold the sender until every pending result has been taken
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic write_first_page(input logic [ADDR_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_first_page(v);
        pool_base = (int'(v) + PAGE_BYTES - 1) >> PAGE_SHIFT;
        if (pool_base > NUM_PAGES - POOL_PAGES)
            pool_base = NUM_PAGES - POOL_PAGES;
    endtask

    task automatic send_random_op();
        int                pick;
        int                sub;
        logic [MODE_W-1:0] m;
        logic [ADDR_W-1:0] a;
        pick = $urandom_range(0, 99);
        a    = ADDR_W'($urandom);
        if (pick < 28)
            m = MODE_ALLOC;
        else if (pick < 58)
        begin
            m   = MODE_FREE;
            sub = $urandom_range(0, 99);
            if (sub < 70)
                a = pool_address();
            else if (sub < 85)
                a[PAGE_SHIFT-1:0] = '0;
        end
        else if (pick < 82)
        begin
            m = (pick < 70) ? MODE_INC : MODE_DEC;
            if ($urandom_range(0, 1) == 1)
                a = pool_address() | ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
        end
        else if (pick < 92)
            m = MODE_QUERY;
        else
            m = MODE_W'($urandom_range(0, 7));
        send_op(m, a);
    endtask

    task automatic run_random(input int n);
        repeat (n)
        begin
            if ($urandom_range(0, 99) == 0)
                wait_drained();
            send_random_op();
        end
    endtask

    task automatic run_directed();
        send_op(MODE_ALLOC, 25'h0000000);         // empty list
        send_op(MODE_QUERY, 25'h1FFFFFF);
        send_op(MODE_FREE,  25'h0010001);         // misaligned
        send_op(MODE_FREE,  25'h000F000);         // below first page
        send_op(MODE_FREE,  25'h0010000);         // first page, count wraps down
        send_op(MODE_FREE,  25'h1FFF000);         // highest page
        send_op(MODE_ALLOC, 25'h0000000);
        send_op(MODE_ALLOC, 25'h1FFFFFF);
        send_op(MODE_ALLOC, 25'h0000000);         // empty again
        send_op(MODE_INC,   25'h0000000);
        send_op(MODE_DEC,   25'h0000000);
        send_op(MODE_DEC,   25'h0000000);         // wrap to all ones
        send_op(MODE_INC,   25'h0000000);         // wrap back to zero
        send_op(MODE_INC,   25'h1FFFFFF);         // unaligned, top page
        send_op(MODE_DEC,   25'h0012345);
        send_op(MODE_FREE,  25'h0020000);
        send_op(MODE_FREE,  25'h0020000);         // double free
        send_op(MODE_ALLOC, 25'h0000000);
        send_op(MODE_ALLOC, 25'h0000000);
        send_op(MODE_ALLOC, 25'h0000000);
        send_op(MODE_SPARE_FIRST, 25'h1FFFFFF);
        send_op(MODE_SPARE_LAST,  25'h0000000);
        send_op(MODE_FREE,  25'h1FFFFFF);         // misaligned top address
        send_op(MODE_QUERY, 25'h0000000);
    endtask

    // Push a run of frees anywhere in the page range, then pop the list dry
    task automatic fill_and_drain();
        repeat (FILL_FREES)
            send_op(MODE_FREE, ADDR_W'($urandom_range(0, NUM_PAGES - 1)) << PAGE_SHIFT);
        send_op(MODE_QUERY, ADDR_W'($urandom));
        repeat (DRAIN_ALLOCS)
            send_op(MODE_ALLOC, ADDR_W'($urandom));
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = MODE_QUERY;
        page_address = '0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        burst_left   = 0;
        pool_base    = 0;
        stall_left   = 0;
        stall_style  = 0;
        idle_cycles  = 0;
        sb           = new();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_first_page(25'h0010000);
        run_directed();

        wait_drained();
        write_first_page(25'h0100000);
        run_random(400);

        wait_drained();
        write_first_page(25'h1FFFFFF);
        run_random(170);

        wait_drained();
        write_first_page(25'h0000000);
        fill_and_drain();

        wait_drained();
        write_first_page(ADDR_W'($urandom));
        run_random(380);

        wait_drained();
        write_first_page(25'h0000000);
        run_random(215);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.flag($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("** page_free_list_refcount: PASSED **");
        else
            $display("** page_free_list_refcount: FAILED **");
        $finish;
    end

endmodule
